// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared codes, defaults and cell control type for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int COUNT_BITS    = 7;
    localparam int OCC_BITS      = 7;

    localparam logic [1:0] OP_PUSH      = 2'd0;
    localparam logic [1:0] OP_POP_FRONT = 2'd1;
    localparam logic [1:0] OP_POP_BACK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    typedef struct packed {
        logic push;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue row: loads a pushed word, shifts toward the front.
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int IDX       = 0,
    parameter int FW        = 7,
    parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  dq_pkg::t_cell_ctrl   i_ctrl,
    input  logic [FW-1:0]        i_fill,
    input  logic [WORD_BITS-1:0] i_push_data,
    input  logic [WORD_BITS-1:0] i_next_data,
    output logic [WORD_BITS-1:0] o_data,
    output logic [WORD_BITS-1:0] o_tap
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 w_is_free;
    logic                 w_is_back;

    assign w_is_free = (i_fill == FW'(IDX));
    assign w_is_back = (i_fill == FW'(IDX + 1));

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_next_data;
        end else if (i_ctrl.push && w_is_free) begin
            n_data = i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_is_back ? r_data : '0;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed words kept in a row of shifting cells.
// A request's first result is registered in the output register as it is taken.
// Throughput: one push or single pop per cycle unless the output stalls.
// A pop of n words blocks input until its last word, one per unstalled cycle.
// Reset: synchronous, clears fill count and control; cell contents persist.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH     = dq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // data, count, zero pad
    input  logic [((WORD_BITS+dq_pkg::COUNT_BITS+7)/8)*8-1:0] i_s_tdata,
    // op
    input  logic [1:0]                                  i_s_tuser,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // word, occupancy, zero pad
    output logic [((WORD_BITS+dq_pkg::OCC_BITS+7)/8)*8-1:0]   o_m_tdata,
    // status
    output logic [1:0]                                  o_m_tuser,
    output logic                                        o_m_tlast
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int XW = (FW > dq_pkg::COUNT_BITS) ? FW : dq_pkg::COUNT_BITS;
    localparam int OW = ((WORD_BITS + dq_pkg::OCC_BITS + 7) / 8) * 8;
    localparam int CB = dq_pkg::COUNT_BITS;

    logic [WORD_BITS-1:0] w_in_data;
    logic [CB-1:0]        w_in_count;
    logic [1:0]           w_in_op;
    logic [XW-1:0]        w_count_x;
    logic [XW-1:0]        w_depth_x;
    logic [CB-1:0]        w_cnt_sat;
    logic                 w_can_emit;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_act;
    logic [1:0]           w_act_op;
    logic [CB-1:0]        w_act_cnt;
    logic [XW-1:0]        w_fill_x;

    logic [WORD_BITS-1:0] w_cell_data [DEPTH];
    logic [WORD_BITS-1:0] w_cell_tap  [DEPTH];
    logic [WORD_BITS-1:0] w_tap_or;
    dq_pkg::t_cell_ctrl   w_ctrl;

    logic                 r_busy, n_busy;
    logic [1:0]           r_op, n_op;
    logic [CB-1:0]        r_remain, n_remain;
    logic [FW-1:0]        r_fill, n_fill;

    logic                 w_emit;
    logic [WORD_BITS-1:0] w_e_word;
    logic [1:0]           w_e_status;
    logic                 w_e_last;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_word;
    logic [1:0]           r_status;
    logic                 r_last;
    logic [CB-1:0]        r_occ;

    assign w_in_data  = i_s_tdata[WORD_BITS-1:0];
    assign w_in_count = i_s_tdata[WORD_BITS+CB-1:WORD_BITS];
    assign w_in_op    = i_s_tuser;

    assign w_count_x = XW'(w_in_count);
    assign w_depth_x = XW'(DEPTH);
    assign w_cnt_sat = (w_count_x > w_depth_x) ? w_depth_x[CB-1:0] : w_in_count;

    assign w_can_emit = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_busy && w_can_emit;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_fill == FW'(DEPTH));
    assign w_empty    = (r_fill == '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_BITS-1:0] w_next;
            if (g == DEPTH - 1) begin : g_end
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_cell_data[g+1];
            end
            dq_cell #(
                .IDX       (g),
                .FW        (FW),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_fill      (r_fill),
                .i_push_data (w_in_data),
                .i_next_data (w_next),
                .o_data      (w_cell_data[g]),
                .o_tap       (w_cell_tap[g])
            );
        end
    endgenerate

    always_comb begin
        w_tap_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tap_or = w_tap_or | w_cell_tap[i];
        end
    end

    assign w_act = (w_accept && (w_in_op == dq_pkg::OP_POP_FRONT ||
                                 w_in_op == dq_pkg::OP_POP_BACK) && w_cnt_sat != '0)
                   || (r_busy && w_can_emit);
    assign w_act_op  = r_busy ? r_op : w_in_op;
    assign w_act_cnt = r_busy ? r_remain : w_cnt_sat;

    always_comb begin
        n_busy     = r_busy;
        n_op       = r_op;
        n_remain   = r_remain;
        n_fill     = r_fill;
        w_emit     = 1'b0;
        w_e_word   = '0;
        w_e_status = dq_pkg::ST_OK;
        w_e_last   = 1'b0;
        w_ctrl     = '0;
        if (w_accept && w_in_op == dq_pkg::OP_PUSH) begin
            w_emit   = 1'b1;
            w_e_last = 1'b1;
            if (w_full) begin
                w_e_status = dq_pkg::ST_OVER;
            end else begin
                w_ctrl.push = 1'b1;
                n_fill      = r_fill + FW'(1);
            end
        end else if (w_act) begin
            w_emit = 1'b1;
            if (w_empty) begin
                w_e_status = dq_pkg::ST_UNDER;
                w_e_last   = 1'b1;
                n_busy     = 1'b0;
            end else begin
                w_e_word     = (w_act_op == dq_pkg::OP_POP_FRONT) ? w_cell_data[0] : w_tap_or;
                w_ctrl.shift = (w_act_op == dq_pkg::OP_POP_FRONT);
                n_fill       = r_fill - FW'(1);
                w_e_last     = (w_act_cnt == CB'(1));
                n_busy       = (w_act_cnt != CB'(1));
                n_remain     = w_act_cnt - CB'(1);
                n_op         = w_act_op;
            end
        end
    end

    assign w_fill_x = XW'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_op        <= dq_pkg::OP_PUSH;
            r_remain    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_op     <= n_op;
            r_remain <= n_remain;
            r_fill   <= n_fill;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_word   <= w_e_word;
            r_status <= w_e_status;
            r_last   <= w_e_last;
            r_occ    <= w_fill_x[CB-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OW'({r_occ, r_word});
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

endmodule

// ===== rtl/core/dq_checker.sv =====
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker #(
    parameter int WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
    input logic                                              i_clk,
    input logic                                              i_rst_n,
    input logic                                              o_s_tready,
    input logic                                              o_m_tvalid,
    input logic                                              i_m_tready,
    input logic [((WORD_BITS+dq_pkg::OCC_BITS+7)/8)*8-1:0]   o_m_tdata,
    input logic [1:0]                                        o_m_tuser,
    input logic                                              o_m_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_error_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == dq_pkg::ST_UNDER || o_m_tuser == dq_pkg::ST_OVER)
        |-> o_m_tlast && o_m_tdata[WORD_BITS-1:0] == '0)
        else $error("error result not final or word nonzero");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("request taken during a pop run");

endmodule

bind double_ended_queue_unit dq_checker #(.WORD_BITS(WORD_BITS)) u_dq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/sv/double_ended_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Self-checking bench for the deque unit. A directed table walks empty,
// full, saturating and ignored requests, then random traffic runs under
// several idle/stall mixes plus a long output hold-off. Every result is
// compared in order against a software copy of the deque or a typed table row.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

    localparam int DEPTH     = dq_pkg::DEPTH_DEF;
    localparam int S_W       = ((dq_pkg::WORD_BITS_DEF + dq_pkg::COUNT_BITS + 7) / 8) * 8;
    localparam int M_W       = ((dq_pkg::WORD_BITS_DEF + dq_pkg::OCC_BITS + 7) / 8) * 8;
    localparam int LIMIT     = 500000;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL      = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  status;
        logic        last;
        logic [6:0]  occ;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] data;
        logic [6:0]  cnt;
        logic [6:0]  reps;
        logic        rnd;
        logic        typed;
        t_result     res;
    } t_row;

    localparam int DIR_N = 24;
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'd1,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_UNDER, 1'b1, 7'd0}},
        '{dq_pkg::OP_POP_BACK,  32'hFFFFFFFF, 7'd0,   7'd1,  1'b0, 1'b0, '0},
        '{OP_UNUSED,            32'hFFFFFFFF, 7'h7F,  7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_PUSH,      32'h7FFFFFFF, 7'd0,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OK, 1'b1, 7'd1}},
        '{dq_pkg::OP_PUSH,      32'h80000000, 7'h7F,  7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OK, 1'b1, 7'd2}},
        '{dq_pkg::OP_PUSH,      32'h00000000, 7'd0,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OK, 1'b1, 7'd3}},
        '{dq_pkg::OP_PUSH,      32'hFFFFFFFF, 7'd0,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OK, 1'b1, 7'd4}},
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'd1,   7'd1,  1'b0, 1'b1,
          '{32'h7FFFFFFF, dq_pkg::ST_OK, 1'b1, 7'd3}},
        '{dq_pkg::OP_POP_BACK,  32'h0,        7'd1,   7'd1,  1'b0, 1'b1,
          '{32'hFFFFFFFF, dq_pkg::ST_OK, 1'b1, 7'd2}},
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'd5,   7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_POP_BACK,  32'h0,        7'h7F,  7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_UNDER, 1'b1, 7'd0}},
        '{dq_pkg::OP_PUSH,      32'h0,        7'd0,   7'd64, 1'b1, 1'b0, '0},
        '{dq_pkg::OP_PUSH,      32'h5A5A5A5A, 7'd0,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OVER, 1'b1, 7'd64}},
        '{dq_pkg::OP_PUSH,      32'hA5A5A5A5, 7'h7F,  7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_OVER, 1'b1, 7'd64}},
        '{dq_pkg::OP_POP_BACK,  32'h0,        7'd2,   7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_PUSH,      32'h0,        7'd0,   7'd2,  1'b1, 1'b0, '0},
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'h7F,  7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_PUSH,      32'h0,        7'd0,   7'd10, 1'b1, 1'b0, '0},
        '{dq_pkg::OP_POP_BACK,  32'h0,        7'd64,  7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_PUSH,      32'h0,        7'd0,   7'd3,  1'b1, 1'b0, '0},
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'd0,   7'd1,  1'b0, 1'b0, '0},
        '{OP_UNUSED,            32'h12345678, 7'd3,   7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_POP_BACK,  32'h0,        7'd3,   7'd1,  1'b0, 1'b0, '0},
        '{dq_pkg::OP_POP_FRONT, 32'h0,        7'd1,   7'd1,  1'b0, 1'b1,
          '{32'h0, dq_pkg::ST_UNDER, 1'b1, 7'd0}}
    };

    logic           i_clk;
    logic           i_rst_n    = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [S_W-1:0] i_s_tdata  = '0;
    logic [1:0]     i_s_tuser  = dq_pkg::OP_PUSH;
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [M_W-1:0] o_m_tdata;
    logic [1:0]     o_m_tuser;
    logic           o_m_tlast;

    double_ended_queue_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // deque shadow
    logic [31:0] shadow_mem [DEPTH];
    int          front_ptr = 0;
    int          back_ptr  = 0;
    int          fill      = 0;
    t_result     pending_results [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int cycles        = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic log_mismatch(input string what, input t_result exp_r, input t_result got_r);
        if (errors < 10)
            $display("%s: exp word=%h st=%0d last=%0d occ=%0d got word=%h st=%0d last=%0d occ=%0d",
                     what, exp_r.word, exp_r.status, exp_r.last, exp_r.occ,
                     got_r.word, got_r.status, got_r.last, got_r.occ);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_result got_r;
        t_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_r = '{o_m_tdata[31:0], o_m_tuser, o_m_tlast, o_m_tdata[38:32]};
            if (pending_results.size() == 0) begin
                log_mismatch("unexpected result", '0, got_r);
            end else begin
                exp_r = pending_results.pop_front();
                if (got_r.word !== exp_r.word || got_r.status !== exp_r.status ||
                    got_r.last !== exp_r.last || got_r.occ !== exp_r.occ)
                    log_mismatch("mismatch", exp_r, got_r);
            end
        end
    end

    task automatic model_request(input logic [1:0] op, input logic [31:0] data,
                                 input logic [6:0] cnt);
        int n;
        logic [31:0] w;
        case (op)
            dq_pkg::OP_PUSH: begin
                if (fill >= DEPTH) begin
                    pending_results.push_back('{32'h0, dq_pkg::ST_OVER, 1'b1, 7'(fill)});
                end else begin
                    shadow_mem[back_ptr] = data;
                    back_ptr = (back_ptr + 1) % DEPTH;
                    fill++;
                    pending_results.push_back('{32'h0, dq_pkg::ST_OK, 1'b1, 7'(fill)});
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
                n = (cnt > DEPTH) ? DEPTH : cnt;
                for (int i = 0; i < n; i++) begin
                    if (fill == 0) begin
                        pending_results.push_back('{32'h0, dq_pkg::ST_UNDER, 1'b1, 7'd0});
                        break;
                    end
                    if (op == dq_pkg::OP_POP_FRONT) begin
                        w = shadow_mem[front_ptr];
                        front_ptr = (front_ptr + 1) % DEPTH;
                    end else begin
                        back_ptr = (back_ptr + DEPTH - 1) % DEPTH;
                        w = shadow_mem[back_ptr];
                    end
                    fill--;
                    pending_results.push_back('{w, dq_pkg::ST_OK, (i + 1 == n), 7'(fill)});
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input logic [1:0] op, input logic [31:0] data,
                                input logic [6:0] cnt, input logic typed,
                                input t_result typed_res);
        int depth0;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_W'({cnt, data});
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        depth0 = pending_results.size();
        model_request(op, data, cnt);
        if (typed) begin
            while (pending_results.size() > depth0)
                void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_requests(input int n, input int push_pct);
        int sent;
        int r;
        logic [1:0]  op;
        logic [31:0] data;
        logic [6:0]  cnt;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < push_pct)
                op = dq_pkg::OP_PUSH;
            else if (r < push_pct + (95 - push_pct) / 2)
                op = dq_pkg::OP_POP_FRONT;
            else if (r < 95)
                op = dq_pkg::OP_POP_BACK;
            else
                op = OP_UNUSED;
            case ($urandom_range(9))
                0:       data = 32'h7FFFFFFF;
                1:       data = 32'h80000000;
                default: data = $urandom;
            endcase
            case ($urandom_range(19))
                0:       cnt = 7'd0;
                1:       cnt = 7'($urandom_range(64, 127));
                2:       cnt = 7'($urandom_range(5, 63));
                default: cnt = 7'($urandom_range(1, 4));
            endcase
            send_request(op, data, cnt, 1'b0, '0);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    initial begin
        t_row row;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_N; k++) begin
            row = DIR_ROWS[k];
            for (int j = 0; j < row.reps; j++)
                send_request(row.op, row.rnd ? 32'($urandom) : row.data, row.cnt,
                             row.typed, row.res);
        end

        random_requests(10, 60);
        snd_idle_pct = 48;
        random_requests(10, 55);
        snd_idle_pct  = 0;
        rcv_stall_pct = 48;
        random_requests(10, 65);
        snd_idle_pct  = 32;
        rcv_stall_pct = 32;
        random_requests(10, 50);

        // long output hold-off: input backs up behind the full output stage
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_seq++;
        random_requests(8, 80);
        wait_drained();
        random_requests(4, 55);

        wait_drained();
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== double_ended_queue_unit.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue_unit.sv
rtl/core/dq_checker.sv
tb/sv/double_ended_queue_unit_tb.sv
